// File: rtl/triangle_circumradius_top_assert.svh
// Assertion macros for the triangle circumradius block.
// Used by the top level; expects i_clk and i_rst_n in the including scope.
`ifndef TRIANGLE_CIRCUMRADIUS_TOP_ASSERT_SVH
`define TRIANGLE_CIRCUMRADIUS_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TRC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/trc_pkg.sv
// Shared types and constants for the triangle circumradius block.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package trc_pkg;

    localparam int SIDE_W           = 12;
    localparam int RADIUS_W         = 40;
    localparam int RADIUS_FRAC_BITS = 16;
    localparam int ROOT_CAP_LOG     = 28;
    localparam int ITER_W           = 7;
    localparam int STOP_W           = 21;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 21;

    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_WIDTH = 1'b1;

    localparam logic [ITER_W-1:0] ITER_LIMIT_RESET = 7'd40;
    localparam logic [STOP_W-1:0] STOP_WIDTH_RESET = 21'd1;

    localparam logic [RADIUS_W-1:0] RADIUS_MAX = '1;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_DEGEN   = 2'd1;
    localparam t_status ST_NOT_TRI = 2'd2;
    localparam t_status ST_SAT     = 2'd3;

    typedef struct packed {
        logic [SIDE_W-1:0] side_one;
        logic [SIDE_W-1:0] side_two;
        logic [SIDE_W-1:0] side_three;
    } t_trc_in;

    typedef struct packed {
        logic [RADIUS_W-1:0] radius;
        t_status             status;
    } t_trc_out;

    // Controller to datapath
    typedef struct packed {
        logic    load_in;
        logic    calc_terms;
        logic    calc_prod;
        logic    calc_p;
        logic    init_bisect;
        logic    calc_mid;
        logic    calc_sq;
        logic    update;
        logic    init_div;
        logic    div_step;
        logic    write_out;
        t_status out_code;
    } t_trc_cmd;

    // Datapath to controller
    typedef struct packed {
        logic p_neg;
        logic p_zero;
        logic stop;
        logic hit;
        logic root_zero;
        logic div_last;
    } t_trc_sts;

endpackage

`default_nettype wire

// File: rtl/trc_ctrl.sv
// Sequencer for the triangle circumradius block: input/output handshake
// and step order. Depends on trc_pkg.
`default_nettype none

module trc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output trc_pkg::t_trc_cmd o_cmd,
    input  trc_pkg::t_trc_sts i_sts
);
    import trc_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_TERMS = 11'b000_0000_0010,
        S_PROD  = 11'b000_0000_0100,
        S_PMUL  = 11'b000_0000_1000,
        S_CHECK = 11'b000_0001_0000,
        S_MID   = 11'b000_0010_0000,
        S_MUL   = 11'b000_0100_0000,
        S_CMP   = 11'b000_1000_0000,
        S_ROOT  = 11'b001_0000_0000,
        S_DIV   = 11'b010_0000_0000,
        S_FIN   = 11'b100_0000_0000
    } t_state;

    t_state   r_state, n_state;
    logic     r_out_valid, n_out_valid;
    t_status  r_code, n_code;
    t_trc_cmd cmd;
    logic     out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_in = 1'b1;
                    n_state     = S_TERMS;
                end
            end
            S_TERMS: begin
                cmd.calc_terms = 1'b1;
                n_state        = S_PROD;
            end
            S_PROD: begin
                cmd.calc_prod = 1'b1;
                n_state       = S_PMUL;
            end
            S_PMUL: begin
                cmd.calc_p = 1'b1;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.p_neg) begin
                    n_code  = ST_NOT_TRI;
                    n_state = S_FIN;
                end else if (i_sts.p_zero) begin
                    n_code  = ST_DEGEN;
                    n_state = S_FIN;
                end else begin
                    cmd.init_bisect = 1'b1;
                    n_state         = S_MID;
                end
            end
            S_MID: begin
                // mid is latched either way; on stop it is the root
                cmd.calc_mid = 1'b1;
                n_state      = i_sts.stop ? S_ROOT : S_MUL;
            end
            S_MUL: begin
                cmd.calc_sq = 1'b1;
                n_state     = S_CMP;
            end
            S_CMP: begin
                cmd.update = 1'b1;
                n_state    = i_sts.hit ? S_ROOT : S_MID;
            end
            S_ROOT: begin
                if (i_sts.root_zero) begin
                    n_code  = ST_SAT;
                    n_state = S_FIN;
                end else begin
                    cmd.init_div = 1'b1;
                    n_code       = ST_OK;
                    n_state      = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hold until the output register is free
                cmd.out_code = r_code;
                if (out_free) begin
                    cmd.write_out = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.write_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_code      <= ST_OK;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_code      <= n_code;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

`default_nettype wire

// File: rtl/trc_dp.sv
// Datapath for the triangle circumradius block: Heron product, bisection
// square root, restoring divider, config and output registers. Uses trc_pkg.
`default_nettype none

module trc_dp #(
    parameter int SIDE_BITS      = 12,
    parameter int ROOT_FRAC_BITS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  trc_pkg::t_trc_in                   i_in,
    input  logic                               i_cfg_we,
    input  logic [trc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [trc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  trc_pkg::t_trc_cmd                  i_cmd,
    output trc_pkg::t_trc_sts                  o_sts,
    output trc_pkg::t_trc_out                  o_out
);
    import trc_pkg::*;

    localparam int TW    = SIDE_BITS + 3;
    localparam int PW    = 4 * TW;
    localparam int RW    = ROOT_CAP_LOG + 1 + ROOT_FRAC_BITS;
    localparam int H     = (RW + 1) / 2;
    localparam int HW    = RW - H;
    localparam int CW    = (2 * RW > PW + 2 * ROOT_FRAC_BITS) ?
                           2 * RW : PW + 2 * ROOT_FRAC_BITS;
    localparam int NW    = 3 * SIDE_BITS + RADIUS_FRAC_BITS + ROOT_FRAC_BITS;
    localparam int QW    = (NW > RADIUS_W) ? NW : RADIUS_W + 1;
    localparam int XW    = (PW > ROOT_CAP_LOG + 2) ? PW : ROOT_CAP_LOG + 2;
    localparam int CNT_W = $clog2(NW);

    localparam logic [XW-1:0] CAP_LIM = XW'(1) << ROOT_CAP_LOG;

    // configuration
    logic [ITER_W-1:0] r_iter_limit;
    logic [STOP_W-1:0] r_stop_width;

    // operands and products
    logic [SIDE_BITS-1:0]        r_a, r_b, r_c;
    logic signed [TW-1:0]        r_t0, r_t1, r_t2, r_t3;
    logic signed [2*TW-1:0]      r_m01, r_m23;
    logic [2*SIDE_BITS-1:0]      r_ab;
    logic signed [PW-1:0]        r_p;
    logic [3*SIDE_BITS-1:0]      r_abc;

    // bisection
    logic [RW-1:0]     r_low, r_high, r_mid;
    logic [ITER_W-1:0] r_steps;
    logic [2*HW-1:0]   r_hh;
    logic [RW-1:0]     r_hl;
    logic [2*H-1:0]    r_ll;

    // divider
    logic [NW-1:0]    r_num, r_quo;
    logic [RW:0]      r_rem;
    logic [CNT_W-1:0] r_cnt;

    t_trc_out r_out, n_out;

    logic signed [TW-1:0]   a_s, b_s, c_s;
    logic signed [2*TW-1:0] prod_01, prod_23;
    logic [2*SIDE_BITS-1:0] ab;
    logic signed [PW-1:0]   p_full;
    logic [3*SIDE_BITS-1:0] abc;
    logic [XW-1:0]          p_x;
    logic [ROOT_CAP_LOG:0]  cap;
    logic [RW:0]            mid_sum;
    logic [RW-1:0]          mid_next, width;
    logic [HW-1:0]          mid_hi;
    logic [H-1:0]           mid_lo;
    logic [2*HW-1:0]        pp_hh;
    logic [RW-1:0]          pp_hl;
    logic [2*H-1:0]         pp_ll;
    logic [CW-1:0]          sq, target;
    logic                   sq_gt, sq_eq, stop;
    logic [RW:0]            rem_sh, root_x;
    logic                   rem_ge;
    logic [QW-1:0]          quo_ext;
    logic                   quo_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter_limit <= ITER_LIMIT_RESET;
            r_stop_width <= STOP_WIDTH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ITER_LIMIT: r_iter_limit <= i_cfg_data[ITER_W-1:0];
                REG_STOP_WIDTH: r_stop_width <= i_cfg_data[STOP_W-1:0];
                default: ;
            endcase
        end
    end

    // Heron terms and products
    assign a_s = signed'(TW'(r_a));
    assign b_s = signed'(TW'(r_b));
    assign c_s = signed'(TW'(r_c));

    assign prod_01 = (2*TW)'(r_t0) * (2*TW)'(r_t1);
    assign prod_23 = (2*TW)'(r_t2) * (2*TW)'(r_t3);
    assign ab      = (2*SIDE_BITS)'(r_a) * (2*SIDE_BITS)'(r_b);
    assign p_full  = PW'(r_m01) * PW'(r_m23);
    assign abc     = (3*SIDE_BITS)'(r_ab) * (3*SIDE_BITS)'(r_c);

    // Upper bound of the root interval: min(P, 2^28) in integer units
    assign p_x = XW'($unsigned(r_p));
    assign cap = (p_x > CAP_LIM) ? CAP_LIM[ROOT_CAP_LOG:0] : p_x[ROOT_CAP_LOG:0];

    assign mid_sum  = (RW+1)'(r_low) + (RW+1)'(r_high);
    assign mid_next = mid_sum[RW:1];
    assign width    = r_high - r_low;
    assign stop     = (r_steps >= r_iter_limit) || (width < RW'(r_stop_width));

    // mid^2 from three half-width partial products
    assign mid_hi = r_mid[RW-1:H];
    assign mid_lo = r_mid[H-1:0];
    assign pp_hh  = (2*HW)'(mid_hi) * (2*HW)'(mid_hi);
    assign pp_hl  = RW'(mid_hi) * RW'(mid_lo);
    assign pp_ll  = (2*H)'(mid_lo) * (2*H)'(mid_lo);

    assign sq     = CW'({r_hh, r_ll}) + (CW'(r_hl) << (H + 1));
    assign target = CW'($unsigned(r_p)) << (2 * ROOT_FRAC_BITS);
    assign sq_gt  = sq > target;
    assign sq_eq  = sq == target;

    // restoring division, one quotient bit per cycle
    assign rem_sh  = {r_rem[RW-1:0], r_num[NW-1]};
    assign root_x  = {1'b0, r_mid};
    assign rem_ge  = rem_sh >= root_x;
    assign quo_ext = QW'(r_quo);
    assign quo_sat = |quo_ext[QW-1:RADIUS_W];

    always_comb begin
        case (i_cmd.out_code)
            ST_OK: begin
                if (quo_sat) begin
                    n_out = '{radius: RADIUS_MAX, status: ST_SAT};
                end else begin
                    n_out = '{radius: quo_ext[RADIUS_W-1:0], status: ST_OK};
                end
            end
            ST_SAT:  n_out = '{radius: RADIUS_MAX, status: ST_SAT};
            default: n_out = '{radius: '0, status: i_cmd.out_code};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_a <= SIDE_BITS'(i_in.side_one);
            r_b <= SIDE_BITS'(i_in.side_two);
            r_c <= SIDE_BITS'(i_in.side_three);
        end
        if (i_cmd.calc_terms) begin
            r_t0 <= a_s + b_s + c_s;
            r_t1 <= -a_s + b_s + c_s;
            r_t2 <= a_s - b_s + c_s;
            r_t3 <= a_s + b_s - c_s;
        end
        if (i_cmd.calc_prod) begin
            r_m01 <= prod_01;
            r_m23 <= prod_23;
            r_ab  <= ab;
        end
        if (i_cmd.calc_p) begin
            r_p   <= p_full;
            r_abc <= abc;
        end
        if (i_cmd.init_bisect) begin
            r_low   <= '0;
            r_high  <= RW'(cap) << ROOT_FRAC_BITS;
            r_steps <= '0;
        end
        if (i_cmd.calc_mid) begin
            r_mid <= mid_next;
        end
        if (i_cmd.calc_sq) begin
            r_hh <= pp_hh;
            r_hl <= pp_hl;
            r_ll <= pp_ll;
        end
        if (i_cmd.update) begin
            if (sq_gt) begin
                r_high <= r_mid;
            end else if (!sq_eq) begin
                r_low <= r_mid;
            end
            r_steps <= r_steps + ITER_W'(1);
        end
        if (i_cmd.init_div) begin
            r_num <= NW'(r_abc) << (RADIUS_FRAC_BITS + ROOT_FRAC_BITS);
            r_quo <= '0;
            r_rem <= '0;
            r_cnt <= CNT_W'(NW - 1);
        end
        if (i_cmd.div_step) begin
            r_num <= r_num << 1;
            r_quo <= {r_quo[NW-2:0], rem_ge};
            r_rem <= rem_ge ? (rem_sh - root_x) : rem_sh;
            r_cnt <= r_cnt - CNT_W'(1);
        end
        if (i_cmd.write_out) begin
            r_out <= n_out;
        end
    end

    assign o_sts.p_neg     = r_p[PW-1];
    assign o_sts.p_zero    = (r_p == '0);
    assign o_sts.stop      = stop;
    assign o_sts.hit       = sq_eq;
    assign o_sts.root_zero = (r_mid == '0);
    assign o_sts.div_last  = (r_cnt == '0);

    assign o_out = r_out;

endmodule

`default_nettype wire

// File: rtl/triangle_circumradius_top.sv
// Triangle circumradius, R = abc / sqrt(P), Heron product P, unsigned Q24.16.
// Each input beat runs the Heron terms and product, then up to iteration_limit bisection
// steps on the squaring unit (ending early on an exact hit), then an NW-bit restoring
// division, NW = 3*SIDE_BITS + 16 + ROOT_FRAC_BITS (60 by default); degenerate or
// non-triangles skip the root and the divider. One item at a time;
// the next beat is taken the cycle after the result is latched. Sync active-low reset.
`default_nettype none

`include "triangle_circumradius_top_assert.svh"

module triangle_circumradius_top #(
    parameter int SIDE_BITS      = 12,
    parameter int ROOT_FRAC_BITS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  trc_pkg::t_trc_in               i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output trc_pkg::t_trc_out              o_out,
    input  logic                           i_cfg_we,
    input  logic [trc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [trc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import trc_pkg::*;

    t_trc_cmd cmd;
    t_trc_sts sts;
    logic     out_reject;
    logic     out_sat;
    logic     in_beat;

    trc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    trc_dp #(
        .SIDE_BITS      (SIDE_BITS),
        .ROOT_FRAC_BITS (ROOT_FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out      (o_out)
    );

    assign out_reject = o_out_valid
                        && (o_out.status == ST_DEGEN || o_out.status == ST_NOT_TRI);
    assign out_sat    = o_out_valid && (o_out.status == ST_SAT);
    assign in_beat    = i_in_valid && o_in_ready;

    `TRC_ASSERT_SAME(a_reject_zero, out_reject, o_out.radius == '0, "reject with nonzero radius")
    `TRC_ASSERT_SAME(a_sat_max, out_sat, o_out.radius == RADIUS_MAX, "saturation not at max")
    `TRC_ASSERT_NEXT(a_busy_after_beat, in_beat, !o_in_ready, "input ready right after beat")
    `TRC_ASSERT_NEXT(a_write_shows, cmd.write_out, o_out_valid, "latched result not presented")

endmodule

`default_nettype wire

// File: dv/triangle_circumradius_top_tb.sv
// Self-checking testbench for triangle_circumradius_top: directed and random triangles
// under several bisection settings, checked beat by beat against a local predictor.
// Depends on trc_pkg and the triangle_circumradius_top RTL.
module triangle_circumradius_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import trc_pkg::*;

    localparam int ROOT_FRAC  = 8;
    localparam int N_DIRECTED = 17;
    localparam int N_PHASES   = 10;

    typedef struct packed {
        logic [SIDE_W-1:0]   s1;
        logic [SIDE_W-1:0]   s2;
        logic [SIDE_W-1:0]   s3;
        logic                typed;
        logic [RADIUS_W-1:0] radius;
        t_status             status;
    } t_dir_row;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_in_valid = 1'b0;
    t_trc_in               i_in       = '0;
    logic                  i_out_ready = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = REG_ITER_LIMIT;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_trc_out              o_out;

    // Limits as the block holds them
    logic [ITER_W-1:0] iter_limit_q = ITER_LIMIT_RESET;
    logic [STOP_W-1:0] stop_width_q = STOP_WIDTH_RESET;

    t_trc_out    pending_radius_q[$];
    t_trc_out    due_res;
    int unsigned radius_beats = 0;
    int unsigned mismatches   = 0;

    // Sides first, then the typed expectation where the row has one
    t_dir_row dir_rows [N_DIRECTED] = '{
        '{12'd0,    12'd0,    12'd0,    1'b1, 40'd0,      ST_DEGEN},
        '{12'd4095, 12'd0,    12'd0,    1'b1, 40'd0,      ST_NOT_TRI},
        '{12'd0,    12'd4095, 12'd4095, 1'b1, 40'd0,      ST_DEGEN},
        '{12'd1,    12'd1,    12'd5,    1'b1, 40'd0,      ST_NOT_TRI},
        '{12'd1,    12'd4095, 12'd1,    1'b1, 40'd0,      ST_NOT_TRI},
        '{12'd4095, 12'd4095, 12'd0,    1'b1, 40'd0,      ST_DEGEN},
        '{12'd1,    12'd2,    12'd3,    1'b1, 40'd0,      ST_DEGEN},
        '{12'd4095, 12'd2048, 12'd2047, 1'b1, 40'd0,      ST_DEGEN},
        '{12'd2730, 12'd1365, 12'd4095, 1'b1, 40'd0,      ST_DEGEN},
        '{12'd3,    12'd4,    12'd5,    1'b1, 40'd163840, ST_OK},
        '{12'd6,    12'd8,    12'd10,   1'b1, 40'd327680, ST_OK},
        '{12'd1,    12'd1,    12'd1,    1'b0, 40'd0,      ST_OK},
        '{12'd4095, 12'd4095, 12'd4095, 1'b0, 40'd0,      ST_OK},
        '{12'd4095, 12'd4095, 12'd1,    1'b0, 40'd0,      ST_OK},
        '{12'd1,    12'd4095, 12'd4095, 1'b0, 40'd0,      ST_OK},
        '{12'd2048, 12'd2048, 12'd2048, 1'b0, 40'd0,      ST_OK},
        '{12'd1365, 12'd2730, 12'd2730, 1'b0, 40'd0,      ST_OK}
    };

    // Fixed settings first (reset values, extremes, defaults rewritten), then random ones
    int unsigned phase_iters [7] = '{40, 64, 1, 0, 127, 12, 40};
    int unsigned phase_stops [7] = '{1, 1, 1048576, 0, 0, 2097151, 1};
    int unsigned phase_beats [7] = '{450, 300, 250, 200, 80, 200, 120};

    triangle_circumradius_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Q28.8 square root of the Heron product by bisection
    function automatic logic [63:0] heron_root(logic [63:0] heron);
        logic [63:0]  lo;
        logic [63:0]  hi;
        logic [63:0]  mid;
        logic [63:0]  cap;
        logic [127:0] target;
        logic [127:0] sq;
        int unsigned  steps;
        bit           hit;
        cap = (heron < (64'd1 << ROOT_CAP_LOG)) ? heron : (64'd1 << ROOT_CAP_LOG);
        if (cap == 0) begin
            cap = 64'd1;
        end
        lo     = '0;
        hi     = cap << ROOT_FRAC;
        target = {64'd0, heron} << (2 * ROOT_FRAC);
        steps  = 0;
        hit    = 1'b0;
        mid    = (lo + hi) >> 1;
        while (!hit && steps < iter_limit_q && (hi - lo) >= stop_width_q) begin
            sq = 128'(mid) * 128'(mid);
            if (sq > target) begin
                hi = mid;
            end else if (sq < target) begin
                lo = mid;
            end else begin
                hit = 1'b1;
            end
            if (!hit) begin
                steps++;
                mid = (lo + hi) >> 1;
            end
        end
        return mid;
    endfunction

    function automatic t_trc_out circumradius_of(t_trc_in sides);
        longint       a;
        longint       b;
        longint       c;
        longint       heron;
        logic [63:0]  root;
        logic [63:0]  abc;
        logic [127:0] quot;
        t_trc_out     res;
        a     = longint'(sides.side_one);
        b     = longint'(sides.side_two);
        c     = longint'(sides.side_three);
        heron = (a + b + c) * (-a + b + c) * (a - b + c) * (a + b - c);
        res.radius = '0;
        if (heron < 0) begin
            res.status = ST_NOT_TRI;
            return res;
        end
        if (heron == 0) begin
            res.status = ST_DEGEN;
            return res;
        end
        root = heron_root(64'(heron));
        if (root == 0) begin
            res.radius = RADIUS_MAX;
            res.status = ST_SAT;
            return res;
        end
        abc  = 64'(a * b * c);
        quot = ({64'd0, abc} << (RADIUS_FRAC_BITS + ROOT_FRAC)) / {64'd0, root};
        if (quot > {88'd0, RADIUS_MAX}) begin
            res.radius = RADIUS_MAX;
            res.status = ST_SAT;
        end else begin
            res.radius = quot[RADIUS_W-1:0];
            res.status = ST_OK;
        end
        return res;
    endfunction

    // Mostly proper triangles with random shape and scale, plus flat, tiny and raw noise
    function automatic t_trc_in random_sides();
        int unsigned kind;
        int unsigned a;
        int unsigned b;
        int unsigned c;
        int unsigned lo;
        int unsigned hi;
        t_trc_in     sides;
        kind = $urandom_range(0, 99);
        a    = $urandom_range(1, (1 << $urandom_range(1, SIDE_W)) - 1);
        b    = $urandom_range(1, (1 << $urandom_range(1, SIDE_W)) - 1);
        if (kind < 70) begin
            lo = (a > b ? a - b : b - a) + 1;
            hi = (a + b - 1 > 4095) ? 4095 : a + b - 1;
            c  = $urandom_range(lo, hi);
        end else if (kind < 80) begin
            c = (a + b <= 4095) ? a + b : (a > b ? a - b : b - a);
        end else if (kind < 85) begin
            a = $urandom_range(0, 3);
            b = $urandom_range(0, 3);
            c = $urandom_range(0, 3);
        end else begin
            a = $urandom_range(0, 4095);
            b = $urandom_range(0, 4095);
            c = $urandom_range(0, 4095);
        end
        case ($urandom_range(0, 2))
            0: sides = '{SIDE_W'(a), SIDE_W'(b), SIDE_W'(c)};
            1: sides = '{SIDE_W'(c), SIDE_W'(a), SIDE_W'(b)};
            default: sides = '{SIDE_W'(b), SIDE_W'(c), SIDE_W'(a)};
        endcase
        return sides;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic send_triangle(t_trc_in sides, bit typed, t_trc_out typed_res,
                                 int unsigned gap);
        i_in       <= sides;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        pending_radius_q.push_back(typed ? typed_res : circumradius_of(sides));
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (pending_radius_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic program_limits(logic [ITER_W-1:0] iters, logic [STOP_W-1:0] width);
        // Upper data bits are don't-care for the iteration limit
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_ITER_LIMIT;
        i_cfg_data <= {14'($urandom), iters};
        @(posedge i_clk);
        i_cfg_idx  <= REG_STOP_WIDTH;
        i_cfg_data <= width;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        iter_limit_q = iters;
        stop_width_q = width;
    endtask

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            radius_beats++;
            if (pending_radius_q.size() == 0) begin
                $error("result beat with no triangle outstanding: radius %0d status %0d",
                       o_out.radius, o_out.status);
                mismatches++;
            end else begin
                due_res = pending_radius_q.pop_front();
                if (o_out.radius !== due_res.radius) begin
                    $error("radius mismatch: expected %0d, got %0d",
                           due_res.radius, o_out.radius);
                    mismatches++;
                end
                if (o_out.status !== due_res.status) begin
                    $error("status mismatch: expected %0d, got %0d",
                           due_res.status, o_out.status);
                    mismatches++;
                end
            end
        end
    end

    // Result sink: random stalls, calm stretches, and one long hold-off to back up the input
    initial begin
        int unsigned stall_left;
        int unsigned calm_left;
        bit          held;
        stall_left = 0;
        calm_left  = 0;
        held       = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!held && radius_beats >= 40) begin
                held       = 1'b1;
                stall_left = 400;
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                if (calm_left > 0) begin
                    calm_left--;
                end else if ($urandom_range(0, 9) == 0) begin
                    calm_left = $urandom_range(50, 300);
                end else if ($urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    initial begin
        int unsigned n_beats;
        int unsigned iters;
        int unsigned width;
        bit          calm;
        t_trc_in     sides;
        t_trc_out    typed_res;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIRECTED; r++) begin
            sides            = '{dir_rows[r].s1, dir_rows[r].s2, dir_rows[r].s3};
            typed_res.radius = dir_rows[r].radius;
            typed_res.status = dir_rows[r].status;
            send_triangle(sides, dir_rows[r].typed, typed_res, pick_gap());
        end

        for (int p = 0; p < N_PHASES; p++) begin
            if (p < 7) begin
                iters   = phase_iters[p];
                width   = phase_stops[p];
                n_beats = phase_beats[p];
            end else begin
                iters   = $urandom_range(0, 64);
                width   = (1 << $urandom_range(0, 20)) + $urandom_range(0, 3);
                n_beats = 130;
            end
            if (p > 0) begin
                // Limits change only with the block idle
                wait_drained();
                repeat (8) @(posedge i_clk);
                program_limits(ITER_W'(iters), STOP_W'(width));
            end
            calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < n_beats; k++) begin
                send_triangle(random_sides(), 1'b0, '0, calm ? 0 : pick_gap());
            end
            i_in_valid <= 1'b0;
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[triangle_circumradius_top] OK");
        end else begin
            $display("[triangle_circumradius_top] ERROR");
        end
        $finish;
    end

    initial begin
        #(60_000_000);
        $display("[triangle_circumradius_top] ERROR");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/trc_pkg.sv
rtl/trc_ctrl.sv
rtl/trc_dp.sv
rtl/triangle_circumradius_top.sv
dv/triangle_circumradius_top_tb.sv
